>>> rtl/core/q4k_pkg.sv
// shared types and constants for the q4_k x q8_k dot product unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package q4k_pkg;

  localparam int InDataW = 112;
  localparam int OutDataW = 32;
  localparam logic [3:0] NibbleMask = 4'hF;
  localparam logic [31:0] QuietNan = 32'h7FC0_0000;
  localparam logic [31:0] NegZero = 32'h8000_0000;

  typedef enum logic [2:0] {
    STEP_CONV_INT,
    STEP_FMA_INT,
    STEP_CONV_MIN,
    STEP_FMA_MIN,
    STEP_MUL_WS,
    STEP_MUL_WM
  } step_t;

  typedef struct packed {
    logic              func;
    logic [15:0]       weight_scale_half;
    logic [15:0]       weight_min_half;
    logic [31:0]       act_scale_bits;
    logic [7:0]        quant_byte;
    logic signed [7:0] act_low;
    logic signed [7:0] act_high;
    logic [5:0]        scale_low;
    logic [5:0]        scale_high;
    logic [5:0]        min_low;
    logic [5:0]        min_high;
    logic              last_item;
  } item_t;

  typedef struct packed {
    logic  start;
    step_t step;
    logic  accum;
    logic  hdr_latch;
    logic  emit;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic pending;
    logic out_busy;
  } dp_status_t;

  typedef struct packed {
    logic               start;
    logic               conv;
    logic               neg;
    logic [31:0]        a;
    logic [31:0]        b;
    logic [31:0]        c;
    logic signed [31:0] ival;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } fpu_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/q4k_fpu.sv
// multi-cycle binary32 fused multiply-add and integer-to-float converter
// depends on q4k_pkg
`timescale 1ns / 1ps
`default_nettype none

module q4k_fpu (
  input  wire                clk,
  input  wire                rst_n,
  input  q4k_pkg::fpu_req_t  req,
  output q4k_pkg::fpu_rsp_t  rsp
);
  import q4k_pkg::*;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MUL  = 5'b00010,
    F_ADD  = 5'b00100,
    F_NORM = 5'b01000,
    F_RND  = 5'b10000
  } fstate_t;

  fstate_t st_r, st_nxt;

  logic               conv_r, neg_r;
  logic [31:0]        a_r, b_r, c_r;
  logic signed [31:0] ival_r;
  logic [47:0]        mp_r;
  logic [23:0]        mc_r;
  logic signed [11:0] ep_r, ec_r, be_r;
  logic               sp_r, sc_r, cz_r, sign_r;
  logic               spec_r;
  logic [31:0]        specv_r;
  logic [79:0]        mag_r;
  logic [31:0]        res_r;
  logic               done_r;

  // unpack
  logic [7:0]  ea, eb, ec;
  logic [22:0] fa, fb, fc;
  logic        nan_a, nan_b, nan_c, inf_a, inf_b, inf_c, zero_a, zero_b, zero_c;
  logic        sp;

  always_comb begin
    ea = a_r[30:23];
    eb = b_r[30:23];
    ec = c_r[30:23];
    fa = a_r[22:0];
    fb = b_r[22:0];
    fc = c_r[22:0];
    nan_a = (ea == 8'hFF) && (fa != 23'd0);
    nan_b = (eb == 8'hFF) && (fb != 23'd0);
    nan_c = (ec == 8'hFF) && (fc != 23'd0);
    inf_a = (ea == 8'hFF) && (fa == 23'd0);
    inf_b = (eb == 8'hFF) && (fb == 23'd0);
    inf_c = (ec == 8'hFF) && (fc == 23'd0);
    zero_a = (ea == 8'd0) && (fa == 23'd0);
    zero_b = (eb == 8'd0) && (fb == 23'd0);
    zero_c = (ec == 8'd0) && (fc == 23'd0);
    sp = a_r[31] ^ b_r[31] ^ neg_r;
  end

  // multiply stage
  logic [23:0]        ma, mb, mc;
  logic signed [11:0] eea, eeb, eec;
  logic               m_spec, m_nan;
  logic [31:0]        m_specv;
  logic [31:0]        iabs;

  always_comb begin
    ma = {(ea != 8'd0), fa};
    mb = {(eb != 8'd0), fb};
    mc = {(ec != 8'd0), fc};
    eea = $signed({4'd0, (ea == 8'd0) ? 8'd1 : ea});
    eeb = $signed({4'd0, (eb == 8'd0) ? 8'd1 : eb});
    eec = $signed({4'd0, (ec == 8'd0) ? 8'd1 : ec});
    m_nan = nan_a | nan_b | nan_c | (inf_a & zero_b) | (inf_b & zero_a) |
            ((inf_a | inf_b) & inf_c & (sp != c_r[31]));
    m_spec = 1'b1;
    m_specv = QuietNan;
    if (m_nan) begin
      m_specv = QuietNan;
    end else if (inf_a | inf_b) begin
      m_specv = {sp, 8'hFF, 23'd0};
    end else if (inf_c) begin
      m_specv = c_r;
    end else if (zero_a | zero_b) begin
      m_specv = zero_c ? {sp & c_r[31], 31'd0} : c_r;
    end else begin
      m_spec = 1'b0;
    end
    iabs = ival_r[31] ? 32'(-ival_r) : ival_r;
  end

  // align and add stage
  logic signed [11:0] tp, tc, ebase, pos, rs;
  logic               plarge, s_l, s_s;
  logic [79:0]        major, aligned;
  logic [47:0]        minor, kept, lmask;
  logic [80:0]        tot;

  always_comb begin
    tp = ep_r + 12'sd48;
    tc = ec_r + 12'sd24;
    plarge = cz_r || (tp >= tc);
    ebase = plarge ? (ep_r - 12'sd31) : (ec_r - 12'sd55);
    major = plarge ? {1'b0, mp_r, 31'd0} : {1'b0, mc_r, 55'd0};
    minor = plarge ? {24'd0, mc_r} : mp_r;
    s_l = plarge ? sp_r : sc_r;
    s_s = plarge ? sc_r : sp_r;
    pos = (plarge ? ec_r : ep_r) - ebase;
    rs = 12'sd1 - pos;
    kept = minor >> rs[5:0];
    lmask = ~({48{1'b1}} << rs[5:0]);
    if (pos >= 12'sd1) begin
      aligned = {32'd0, minor} << pos[6:0];
    end else if (rs > 12'sd48) begin
      aligned = {79'd0, |minor};
    end else begin
      aligned = {31'd0, kept, |(minor & lmask)};
    end
    if (s_l == s_s) begin
      tot = {1'b0, major} + {1'b0, aligned};
    end else begin
      tot = {1'b0, major} - {1'b0, aligned};
    end
  end

  // rounding stage
  logic signed [11:0] rsh, ben;
  logic [79:0]        sh, rmask;
  logic               lost, g, stk, up;
  logic [23:0]        q, qf;
  logic [24:0]        q25;
  logic [31:0]        rnd_res;

  always_comb begin
    rsh = (be_r < 12'sd1) ? (12'sd1 - be_r) : 12'sd0;
    rmask = ~({80{1'b1}} << rsh[6:0]);
    if (rsh >= 12'sd80) begin
      sh = 80'd0;
      lost = |mag_r;
    end else begin
      sh = mag_r >> rsh[6:0];
      lost = |(mag_r & rmask);
    end
    ben = (be_r < 12'sd1) ? 12'sd1 : be_r;
    q = sh[79:56];
    g = sh[55];
    stk = (|sh[54:0]) | lost;
    up = g & (stk | q[0]);
    q25 = {1'b0, q} + {24'd0, up};
    if (q25[24]) begin
      qf = q25[24:1];
      ben = ben + 12'sd1;
    end else begin
      qf = q25[23:0];
    end
    if (spec_r) begin
      rnd_res = specv_r;
    end else if (!qf[23]) begin
      rnd_res = {sign_r, 8'd0, qf[22:0]};
    end else if (ben >= 12'sd255) begin
      rnd_res = {sign_r, 8'hFF, 23'd0};
    end else begin
      rnd_res = {sign_r, ben[7:0], qf[22:0]};
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      F_IDLE: if (req.start) st_nxt = F_MUL;
      F_MUL: begin
        if (conv_r) st_nxt = (iabs == 32'd0) ? F_RND : F_NORM;
        else st_nxt = m_spec ? F_RND : F_ADD;
      end
      F_ADD: st_nxt = (tot[79:0] == 80'd0) ? F_RND : F_NORM;
      F_NORM: if (mag_r[79] || be_r <= 12'sd1) st_nxt = F_RND;
      F_RND: st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      done_r <= (st_r == F_RND);
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      F_IDLE: begin
        if (req.start) begin
          conv_r <= req.conv;
          neg_r <= req.neg;
          a_r <= req.a;
          b_r <= req.b;
          c_r <= req.c;
          ival_r <= req.ival;
        end
      end
      F_MUL: begin
        mp_r <= ma * mb;
        mc_r <= mc;
        ep_r <= eea + eeb - 12'sd300;
        ec_r <= eec - 12'sd150;
        sp_r <= sp;
        sc_r <= c_r[31];
        cz_r <= zero_c;
        if (conv_r) begin
          spec_r <= (iabs == 32'd0);
          specv_r <= 32'd0;
          mag_r <= {48'd0, iabs};
          be_r <= 12'sd206;
          sign_r <= ival_r[31];
        end else begin
          spec_r <= m_spec;
          specv_r <= m_specv;
        end
      end
      F_ADD: begin
        be_r <= ebase + 12'sd206;
        if (tot[80]) begin
          mag_r <= 80'(-tot);
          sign_r <= s_s;
        end else begin
          mag_r <= tot[79:0];
          sign_r <= s_l;
        end
        if (tot[79:0] == 80'd0) begin
          spec_r <= 1'b1;
          specv_r <= 32'd0;
        end
      end
      F_NORM: begin
        if (!mag_r[79] && be_r > 12'sd1) begin
          if (mag_r[79:72] == 8'd0 && be_r > 12'sd8) begin
            mag_r <= mag_r << 8;
            be_r <= be_r - 12'sd8;
          end else begin
            mag_r <= mag_r << 1;
            be_r <= be_r - 12'sd1;
          end
        end
      end
      F_RND: res_r <= rnd_res;
      default: ;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.res = res_r;

endmodule

`default_nettype wire

>>> rtl/core/q4k_dp.sv
// datapath: integer sums, scale and accumulator registers, result register
// depends on q4k_pkg and q4k_fpu
`timescale 1ns / 1ps
`default_nettype none

module q4k_dp (
  input  wire                  clk,
  input  wire                  rst_n,
  input  q4k_pkg::item_t       item,
  input  q4k_pkg::dp_cmd_t     cmd,
  output q4k_pkg::dp_status_t  status,
  input  wire                  out_tready,
  output logic                 out_valid,
  output logic [31:0]          out_data
);
  import q4k_pkg::*;

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  p;
    logic [9:0]  mn;
    logic [31:0] r;
    e = h[14:10];
    m = h[9:0];
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) p = 4'(i);
    end
    mn = m << (4'd10 - p);
    if (e == 5'h1F) begin
      r = (m != 10'd0) ? ({h[15], 31'd0} | QuietNan | {9'd0, m, 13'd0})
                       : {h[15], 8'hFF, 23'd0};
    end else if (e == 5'd0) begin
      r = (m == 10'd0) ? {h[15], 31'd0}
                       : {h[15], 8'(p) + 8'd103, mn, 13'd0};
    end else begin
      r = {h[15], 8'(e) + 8'd112, m, 13'd0};
    end
    return r;
  endfunction

  logic [31:0] int_sum_r, acc_r, sws_r, sms_r, tmp_r;
  logic [23:0] min_sum_r;
  logic        pending_r;
  logic [15:0] hws_r, hwm_r;
  logic [31:0] hact_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;

  logic [3:0]         lo, hi;
  logic signed [17:0] p_lo, p_hi;
  logic signed [18:0] p_sum;
  logic signed [15:0] m_sum;
  fpu_req_t           freq;
  fpu_rsp_t           frsp;

  always_comb begin
    lo = item.quant_byte[3:0] & NibbleMask;
    hi = item.quant_byte[7:4] & NibbleMask;
    p_lo = $signed({1'b0, lo}) * $signed(item.act_low) * $signed({1'b0, item.scale_low});
    p_hi = $signed({1'b0, hi}) * $signed(item.act_high) * $signed({1'b0, item.scale_high});
    p_sum = {p_lo[17], p_lo} + {p_hi[17], p_hi};
    m_sum = $signed(item.act_low) * $signed({1'b0, item.min_low}) +
            $signed(item.act_high) * $signed({1'b0, item.min_high});
  end

  always_comb begin
    freq.start = cmd.start;
    freq.conv = 1'b0;
    freq.neg = 1'b0;
    freq.a = tmp_r;
    freq.b = sws_r;
    freq.c = acc_r;
    freq.ival = $signed(int_sum_r);
    case (cmd.step)
      STEP_CONV_INT: freq.conv = 1'b1;
      STEP_FMA_INT: ;
      STEP_CONV_MIN: begin
        freq.conv = 1'b1;
        freq.ival = $signed({{8{min_sum_r[23]}}, min_sum_r});
      end
      STEP_FMA_MIN: begin
        freq.b = sms_r;
        freq.neg = 1'b1;
      end
      STEP_MUL_WS: begin
        freq.a = half_to_single(hws_r);
        freq.b = hact_r;
        freq.c = NegZero;
      end
      STEP_MUL_WM: begin
        freq.a = half_to_single(hwm_r);
        freq.b = hact_r;
        freq.c = NegZero;
      end
      default: ;
    endcase
  end

  q4k_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (freq),
    .rsp   (frsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_sum_r <= 32'd0;
      min_sum_r <= 24'd0;
      acc_r <= 32'd0;
      sws_r <= 32'd0;
      sms_r <= 32'd0;
      pending_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (cmd.accum) begin
        int_sum_r <= int_sum_r + {{13{p_sum[18]}}, p_sum};
        min_sum_r <= min_sum_r + {{8{m_sum[15]}}, m_sum};
        pending_r <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        acc_r <= 32'd0;
      end
      if (frsp.done) begin
        case (cmd.step)
          STEP_CONV_INT, STEP_CONV_MIN: ;
          STEP_FMA_INT: acc_r <= frsp.res;
          STEP_FMA_MIN: begin
            acc_r <= frsp.res;
            int_sum_r <= 32'd0;
            min_sum_r <= 24'd0;
            pending_r <= 1'b0;
          end
          STEP_MUL_WS: sws_r <= frsp.res;
          STEP_MUL_WM: sms_r <= frsp.res;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hdr_latch) begin
      hws_r <= item.weight_scale_half;
      hwm_r <= item.weight_min_half;
      hact_r <= item.act_scale_bits;
    end
    if (frsp.done && (cmd.step == STEP_CONV_INT || cmd.step == STEP_CONV_MIN)) begin
      tmp_r <= frsp.res;
    end
    if (cmd.emit) out_data_r <= acc_r;
  end

  assign status.done = frsp.done;
  assign status.pending = pending_r;
  assign status.out_busy = out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

`default_nettype wire

>>> rtl/core/q4k_ctrl.sv
// controller: input handshake and sequencing of the float steps
// depends on q4k_pkg
`timescale 1ns / 1ps
`default_nettype none

module q4k_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  input  wire                  func,
  input  wire                  last_item,
  input  q4k_pkg::dp_status_t  status,
  output logic                 in_tready,
  output q4k_pkg::dp_cmd_t     cmd
);
  import q4k_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;
  logic   hdr_r, hdr_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    hdr_nxt = hdr_r;
    cmd.start = 1'b0;
    cmd.step = step_r;
    cmd.accum = 1'b0;
    cmd.hdr_latch = 1'b0;
    cmd.emit = 1'b0;
    in_tready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (func) begin
            cmd.accum = 1'b1;
            if (last_item) begin
              hdr_nxt = 1'b0;
              step_nxt = STEP_CONV_INT;
              state_nxt = S_ISSUE;
            end
          end else begin
            cmd.hdr_latch = 1'b1;
            hdr_nxt = 1'b1;
            step_nxt = status.pending ? STEP_CONV_INT : STEP_MUL_WS;
            state_nxt = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        cmd.start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (status.done) begin
          state_nxt = S_ISSUE;
          case (step_r)
            STEP_CONV_INT: step_nxt = STEP_FMA_INT;
            STEP_FMA_INT:  step_nxt = STEP_CONV_MIN;
            STEP_CONV_MIN: step_nxt = STEP_FMA_MIN;
            STEP_FMA_MIN: begin
              if (hdr_r) step_nxt = STEP_MUL_WS;
              else state_nxt = S_EMIT;
            end
            STEP_MUL_WS: step_nxt = STEP_MUL_WM;
            STEP_MUL_WM: state_nxt = S_IDLE;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= STEP_CONV_INT;
      hdr_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      hdr_r <= hdr_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/q4k_q8k_dot_product_unit.sv
// top level of the q4_k x q8_k row dot product unit
// depends on q4k_pkg, q4k_ctrl, q4k_dp
`timescale 1ns / 1ps
`default_nettype none

// Streams one weight byte per beat: a data beat that is not the last of a row is
// taken while the controller stays idle, so such beats follow each other at full
// rate. A header beat or the last data beat of a row runs a sequence on the single
// shared float unit: folding a superblock is four float steps (two int-to-float
// conversions, two fused multiply-adds) and a header adds two multiplies. A step
// skips to rounding when a factor is zero, an operand is infinite or nan, or a
// converted integer is zero; else its length is set by the normalising shift loop
// (eight bits or one bit a cycle). The last beat of a row also loads the output
// register once it is free. in_tready stays low during a sequence. The result
// waits in an output register while new beats are taken.
module q4k_q8k_dot_product_unit (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // weight_scale_half, weight_min_half, act_scale_bits, quant_byte, act_low,
  // act_high, scale_low, scale_high, min_low, min_high
  input  wire [q4k_pkg::InDataW-1:0] in_tdata,
  input  wire          in_tuser,   // func
  input  wire          in_tlast,   // last_item
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [q4k_pkg::OutDataW-1:0] out_tdata  // dot_result_bits
);
  import q4k_pkg::*;

  item_t      item;
  dp_cmd_t    cmd;
  dp_status_t status;

  always_comb begin
    item.func = in_tuser;
    item.weight_scale_half = in_tdata[15:0];
    item.weight_min_half = in_tdata[31:16];
    item.act_scale_bits = in_tdata[63:32];
    item.quant_byte = in_tdata[71:64];
    item.act_low = in_tdata[79:72];
    item.act_high = in_tdata[87:80];
    item.scale_low = in_tdata[93:88];
    item.scale_high = in_tdata[99:94];
    item.min_low = in_tdata[105:100];
    item.min_high = in_tdata[111:106];
    item.last_item = in_tlast;
  end

  q4k_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .func      (item.func),
    .last_item (item.last_item),
    .status    (status),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  q4k_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .cmd        (cmd),
    .status     (status),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_data   (out_tdata)
  );

`ifndef SYNTHESIS
  a_hdr_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> !in_tready)
    else $error("header beat did not start a sequence");

  a_data_full_rate: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser && !in_tlast |=> in_tready)
    else $error("plain data beat stalled the input");

  a_result_after_fold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared outside a fold sequence");
`endif

endmodule

`default_nettype wire
